/* design/xoshiro256ss_random_source_assert.svh */
// Assertion macros shared by the generator block.
`ifndef XOSHIRO256SS_RANDOM_SOURCE_ASSERT_SVH
`define XOSHIRO256SS_RANDOM_SOURCE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define XRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define XRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/xrs_pkg.sv */
`timescale 1ns / 1ps
package xrs_pkg;

  localparam logic [63:0] GoldenStep = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMulA    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB    = 64'h94d049bb133111eb;

  typedef enum logic [2:0] {
    ACT_LOAD   = 3'd0,
    ACT_SEED   = 3'd1,
    ACT_DRAW32 = 3'd2,
    ACT_DRAW31 = 3'd3,
    ACT_BOUND  = 3'd4,
    ACT_FRAC53 = 3'd5,
    ACT_NOP6   = 3'd6,
    ACT_NOP7   = 3'd7
  } action_e;

  // Classified command handed from the front to the back.
  typedef struct packed {
    action_e     action;
    logic [1:0]  word_index;
    logic [63:0] operand;
    logic [31:0] lo;
    logic [31:0] span;       // hi - lo + 1, modulo 2^32
    logic        empty_rng;  // max <= min
    logic        full_rng;   // span wraps to zero
  } cmd_t;

  typedef struct packed {
    logic [52:0] draw;
    logic [31:0] bounded;
  } res_t;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (64 - n));
  endfunction

endpackage

/* design/xoshiro256ss_random_source.sv */
`timescale 1ns / 1ps
// Bounded draws over a partial range run two 32-step remainder passes in the
// back (limit, then the accepted sample); a rejected sample is drawn again.
// The back handles one item at a time; a two-entry command queue and
// a one-result register let the input and output sides stall on their own.
// Reset (async, active low): word 0 is the golden constant, the rest zero.
module xoshiro256ss_random_source
  import xrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         action_i,
  input  logic [1:0]         word_index_i,
  input  logic [63:0]        operand_i,
  input  logic signed [31:0] min_value_i,
  input  logic signed [31:0] max_value_i,
  output logic               empty,
  input  logic               pop,
  output logic [52:0]        draw_o,
  output logic signed [31:0] bounded_o
);

`include "xoshiro256ss_random_source_assert.svh"

  logic cmd_valid, cmd_take, res_valid, busy;
  cmd_t cmd;
  res_t res;

  xrs_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .action_i, .word_index_i, .operand_i, .min_value_i, .max_value_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  xrs_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(pop), .busy_o(busy)
  );

  assign empty     = !res_valid;
  assign draw_o    = res.draw;
  assign bounded_o = res.bounded;

  `XRS_ASSERT_IMP(a_take_idle, cmd_take, !busy && !res_valid)
  `XRS_ASSERT_NEXT(a_res_holds, res_valid && !pop, res_valid && $stable(res))
  `XRS_ASSERT_IMP(a_take_has_cmd, cmd_take && cmd_valid, !res_valid)

endmodule

/* design/xrs_front.sv */
`timescale 1ns / 1ps
module xrs_front
  import xrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [2:0]        action_i,
  input  logic [1:0]        word_index_i,
  input  logic [63:0]       operand_i,
  input  logic signed [31:0] min_value_i,
  input  logic signed [31:0] max_value_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_take_i
);

  // Two-entry queue between front and back.
  cmd_t       mem_q [2];
  logic       wr_q, rd_q, wr_d, rd_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_new;
  logic       do_push, do_pop;

  always_comb begin
    cmd_new.action     = action_e'(action_i);
    cmd_new.word_index = word_index_i;
    cmd_new.operand    = operand_i;
    cmd_new.lo         = min_value_i;
    cmd_new.span       = max_value_i - min_value_i + 32'd1;
    cmd_new.empty_rng  = (max_value_i <= min_value_i);
    cmd_new.full_rng   = (min_value_i == 32'sh80000000) && (max_value_i == 32'sh7fffffff);
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_new;
    end
  end

endmodule

/* design/xrs_back.sv */
`timescale 1ns / 1ps
module xrs_back
  import xrs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  input  cmd_t  cmd_i,
  output logic  cmd_take_o,
  output logic  res_valid_o,
  output res_t  res_o,
  input  logic  res_take_i,
  output logic  busy_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MIX0  = 4'd1;   // advance acc, z ^ z>>30
  localparam logic [3:0] S_MIX1  = 4'd2;   // z ^ z>>27
  localparam logic [3:0] S_MIX2  = 4'd3;   // z ^ z>>31, store word
  localparam logic [3:0] S_FIX   = 4'd4;
  localparam logic [3:0] S_LIM   = 4'd5;   // (0-span) % span
  localparam logic [3:0] S_DRAW  = 4'd6;   // check sample against limit, load divider
  localparam logic [3:0] S_MOD   = 4'd7;   // x % span
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_DRAWR = 4'd9;   // one generator step, plain draw result
  localparam logic [3:0] S_MULS  = 4'd10;  // 5 multiply registered
  localparam logic [3:0] S_MUL9  = 4'd11;
  localparam logic [3:0] S_MULA  = 4'd12;  // multiply A, 16 bits a step
  localparam logic [3:0] S_MULB  = 4'd13;  // multiply B, 16 bits a step

  logic [3:0]  st_q, st_d;
  logic [63:0] w_q [4];
  cmd_t        c_q;
  logic [63:0] acc_q;
  // Mixer multiply: multiplicand, constant and running product.
  logic [63:0] mz_q, mk_q, mp_q;
  logic [1:0]  kcnt_q;
  logic [1:0]  wi_q;
  logic [31:0] limit_q;
  logic        stuck_q;
  // Restoring divider: remainder only.
  logic [31:0] dvd_q, rem_q;
  logic [5:0]  dcnt_q;
  logic [32:0] trial;
  logic        res_v_q;
  res_t        res_q;
  logic [63:0] t_q;

  logic        st_zero;
  logic [63:0] n0, n1, n2, n3, zsh;

  assign st_zero = ((w_q[0] | w_q[1] | w_q[2] | w_q[3]) == 64'd0);
  assign trial   = {rem_q, dvd_q[31]} - {1'b0, c_q.span};

  always_comb begin
    n2 = w_q[2] ^ w_q[0];
    n3 = w_q[3] ^ w_q[1];
    n1 = w_q[1] ^ n2;
    n0 = w_q[0] ^ n3;
    n2 = n2 ^ (w_q[1] << 17);
    n3 = rotl(n3, 45);
    zsh = acc_q + GoldenStep;
  end

  assign cmd_take_o  = (st_q == S_IDLE) && !res_v_q;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
  assign busy_o      = (st_q != S_IDLE);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (cmd_valid_i && cmd_take_o) begin
        unique case (cmd_i.action)
          ACT_LOAD:   st_d = S_FIX;
          ACT_SEED:   st_d = S_MIX0;
          ACT_DRAW32, ACT_DRAW31, ACT_FRAC53: st_d = S_MULS;
          ACT_BOUND:  st_d = cmd_i.empty_rng ? S_OUT : (cmd_i.full_rng ? S_MULS : S_LIM);
          default:    st_d = S_OUT;
        endcase
      end
      S_MIX0:  st_d = S_MULA;
      S_MULA:  if (kcnt_q == 2'd3) st_d = S_MIX1;
      S_MIX1:  st_d = S_MULB;
      S_MULB:  if (kcnt_q == 2'd3) st_d = S_MIX2;
      S_MIX2:  st_d = (wi_q == 2'd3) ? S_FIX : S_MIX0;
      S_FIX:   st_d = S_OUT;
      S_LIM:   if (dcnt_q == 6'd32) st_d = S_MULS;
      S_MULS:  st_d = S_MUL9;
      S_MUL9:  st_d = S_DRAWR;
      S_DRAWR: st_d = (c_q.action == ACT_BOUND && !c_q.full_rng) ? S_DRAW : S_OUT;
      S_DRAW:  st_d = (t_q[63:32] >= limit_q || stuck_q) ? S_MOD : S_MULS;
      S_MOD:   if (dcnt_q == 6'd32) st_d = S_OUT;
      S_OUT:   st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      res_v_q <= 1'b0;
      w_q[0]  <= GoldenStep;
      w_q[1]  <= 64'd0;
      w_q[2]  <= 64'd0;
      w_q[3]  <= 64'd0;
    end else begin
      st_q <= st_d;
      if (res_v_q && res_take_i) begin
        res_v_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: if (cmd_valid_i && cmd_take_o && cmd_i.action == ACT_LOAD) begin
          w_q[cmd_i.word_index] <= cmd_i.operand;
        end
        S_MIX2: w_q[wi_q] <= mp_q ^ (mp_q >> 31);
        S_FIX: if (st_zero && (c_q.action == ACT_SEED || c_q.word_index == 2'd3)) begin
          w_q[0] <= GoldenStep;
        end
        S_DRAWR: begin
          // advance the generator; t_q holds the scrambled output
          w_q[0] <= n0;
          w_q[1] <= n1;
          w_q[2] <= n2;
          w_q[3] <= n3;
        end
        S_OUT: res_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: if (cmd_valid_i && cmd_take_o) begin
        c_q    <= cmd_i;
        acc_q  <= cmd_i.operand;
        wi_q   <= 2'd0;
        dvd_q  <= 32'd0 - cmd_i.span;
        rem_q  <= 32'd0;
        dcnt_q <= 6'd0;
        res_q  <= {53'd0, (cmd_i.action == ACT_BOUND && cmd_i.empty_rng) ? cmd_i.lo : 32'd0};
      end
      S_MIX0: begin
        acc_q  <= zsh;
        mz_q   <= zsh ^ (zsh >> 30);
        mk_q   <= MixMulA;
        mp_q   <= 64'd0;
        kcnt_q <= 2'd0;
      end
      S_MULA, S_MULB: begin
        // accumulate one 16-bit slice of the constant per step
        mp_q   <= mp_q + mz_q * {48'd0, mk_q[15:0]};
        mz_q   <= mz_q << 16;
        mk_q   <= mk_q >> 16;
        kcnt_q <= kcnt_q + 2'd1;
      end
      S_MIX1: begin
        mz_q   <= mp_q ^ (mp_q >> 27);
        mk_q   <= MixMulB;
        mp_q   <= 64'd0;
        kcnt_q <= 2'd0;
      end
      S_MIX2: wi_q <= wi_q + 2'd1;
      S_LIM, S_MOD: begin
        // one quotient bit a step
        if (dcnt_q != 6'd32) begin
          rem_q  <= trial[32] ? {rem_q[30:0], dvd_q[31]} : trial[31:0];
          dvd_q  <= {dvd_q[30:0], 1'b0};
          dcnt_q <= dcnt_q + 6'd1;
        end else if (st_q == S_LIM) begin
          limit_q <= rem_q;
        end else begin
          res_q.bounded <= c_q.lo + rem_q;
        end
      end
      S_MULS: begin
        t_q     <= w_q[1] * 64'd5;
        stuck_q <= st_zero;
      end
      S_MUL9: t_q <= rotl(t_q, 7) * 64'd9;
      S_DRAWR: begin
        unique case (c_q.action)
          ACT_DRAW32: res_q.draw <= {21'd0, t_q[63:32]};
          ACT_DRAW31: res_q.draw <= {22'd0, t_q[63:33]};
          ACT_FRAC53: res_q.draw <= t_q[63:11];
          default:    res_q.bounded <= c_q.lo + t_q[63:32];
        endcase
      end
      S_DRAW: begin
        dvd_q  <= t_q[63:32];
        rem_q  <= 32'd0;
        dcnt_q <= 6'd0;
      end
      default: ;
    endcase
  end

endmodule

/* dv/xoshiro256ss_random_source_test.sv */
`timescale 1ns / 1ps
module xoshiro256ss_random_source_test;
  import xrs_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned RandomBeats = 1600;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [2:0]         action_i = ACT_LOAD;
  logic [1:0]         word_index_i = '0;
  logic [63:0]        operand_i = '0;
  logic signed [31:0] min_value_i = '0;
  logic signed [31:0] max_value_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [52:0]        draw_o;
  logic signed [31:0] bounded_o;

  xoshiro256ss_random_source dut (.*);

  always #4 clk_i = ~clk_i;

  typedef struct {
    action_e     action;
    logic [1:0]  word_index;
    logic [63:0] operand;
    logic [31:0] min_value;
    logic [31:0] max_value;
  } beat_t;

  typedef struct {
    logic [52:0] draw;
    logic [31:0] bounded;
  } outcome_t;

  // Directed row: expected outcome typed in where it is obvious.
  typedef struct {
    beat_t    beat;
    bit       fixed;
    outcome_t want;
  } row_t;

  logic [63:0] gen_state [4];
  outcome_t    pending_outcomes [$];
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned bounded_seen = 0;
  bit          hold_off = 1'b0;
  bit          stimulus_done = 1'b0;

  function automatic logic [63:0] rot64(logic [63:0] v, int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] state_advance();
    logic [63:0] res, sh;
    res = rot64(gen_state[1] * 64'd5, 7) * 64'd9;
    sh = gen_state[1] << 17;
    gen_state[2] ^= gen_state[0];
    gen_state[3] ^= gen_state[1];
    gen_state[1] ^= gen_state[2];
    gen_state[0] ^= gen_state[3];
    gen_state[2] ^= sh;
    gen_state[3] = rot64(gen_state[3], 45);
    return res;
  endfunction

  function automatic logic [63:0] splitmix(ref logic [63:0] acc);
    logic [63:0] z;
    acc += 64'h9e3779b97f4a7c15;
    z = acc;
    z = (z ^ (z >> 30)) * 64'hbf58476d1ce4e5b9;
    z = (z ^ (z >> 27)) * 64'h94d049bb133111eb;
    return z ^ (z >> 31);
  endfunction

  function automatic void fix_zero_state();
    if ((gen_state[0] | gen_state[1] | gen_state[2] | gen_state[3]) == '0)
      gen_state[0] = 64'h9e3779b97f4a7c15;
  endfunction

  function automatic logic [31:0] draw_in_range(logic [31:0] lo, logic [31:0] hi);
    logic [31:0] span, limit, x;
    logic [63:0] g;
    bit stuck;
    if ($signed(hi) <= $signed(lo)) return lo;
    span = hi - lo + 32'd1;
    if (span == '0) begin
      g = state_advance();
      return lo + g[63:32];
    end
    limit = (32'd0 - span) % span;
    forever begin
      stuck = (gen_state[0] | gen_state[1] | gen_state[2] | gen_state[3]) == '0;
      g = state_advance();
      x = g[63:32];
      if (x >= limit || stuck) break;
    end
    return lo + (x % span);
  endfunction

  function automatic outcome_t predict_outcome(beat_t b);
    outcome_t o;
    logic [63:0] acc, g;
    o.draw = '0;
    o.bounded = '0;
    case (b.action)
      ACT_LOAD: begin
        gen_state[b.word_index] = b.operand;
        if (b.word_index == 2'd3) fix_zero_state();
      end
      ACT_SEED: begin
        acc = b.operand;
        for (int i = 0; i < 4; i++) gen_state[i] = splitmix(acc);
        fix_zero_state();
      end
      ACT_DRAW32: begin
        g = state_advance();
        o.draw = 53'(g >> 32);
      end
      ACT_DRAW31: begin
        g = state_advance();
        o.draw = 53'(g >> 33);
      end
      ACT_BOUND: o.bounded = draw_in_range(b.min_value, b.max_value);
      ACT_FRAC53: begin
        g = state_advance();
        o.draw = 53'(g >> 11);
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic beat_t make_beat(action_e a, logic [1:0] w, logic [63:0] op,
                                      logic [31:0] lo, logic [31:0] hi);
    beat_t b;
    b.action = a;
    b.word_index = w;
    b.operand = op;
    b.min_value = lo;
    b.max_value = hi;
    return b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic beat_t random_beat();
    int unsigned pick;
    logic [31:0] lo, hi;
    pick = $urandom_range(0, 99);
    lo = $urandom();
    hi = $urandom();
    case ($urandom_range(0, 3))
      0: hi = lo + $urandom_range(1, 16);
      1: hi = lo + $urandom_range(0, 1000);
      default: ;
    endcase
    if ($urandom_range(0, 49) == 0) begin
      lo = 32'h8000_0000;
      hi = 32'h7fff_ffff;
    end
    if (pick < 3) return make_beat(ACT_LOAD, 2'($urandom()), rand64(), lo, hi);
    if (pick < 6) return make_beat(ACT_SEED, 2'($urandom()), rand64(), lo, hi);
    if (pick < 8) return make_beat(action_e'($urandom_range(6, 7)), 2'($urandom()),
                                   rand64(), lo, hi);
    case ($urandom_range(0, 3))
      0: return make_beat(ACT_DRAW32, 2'($urandom()), rand64(), lo, hi);
      1: return make_beat(ACT_DRAW31, 2'($urandom()), rand64(), lo, hi);
      2: return make_beat(ACT_BOUND, 2'($urandom()), rand64(), lo, hi);
      default: return make_beat(ACT_FRAC53, 2'($urandom()), rand64(), lo, hi);
    endcase
  endfunction

  task automatic send_beat(beat_t b, bit fixed, outcome_t want);
    outcome_t o;
    action_i <= b.action;
    word_index_i <= b.word_index;
    operand_i <= b.operand;
    min_value_i <= b.min_value;
    max_value_i <= b.max_value;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    o = predict_outcome(b);
    if (fixed && (o.draw != want.draw || o.bounded != want.bounded)) begin
      $error("table row disagrees with predictor for action %0d", b.action);
      errors++;
    end
    pending_outcomes.push_back(fixed ? want : o);
    beats_sent++;
    @(negedge clk_i);
    // Hold push through bursts; drop it for a gap now and then.
    if ($urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  initial begin
    row_t table_rows [$];
    outcome_t zero_out;
    row_t r;
    zero_out.draw = '0;
    zero_out.bounded = '0;
    gen_state[0] = 64'h9e3779b97f4a7c15;
    for (int i = 1; i < 4; i++) gen_state[i] = '0;

    r.fixed = 1'b0;
    r.want = zero_out;
    // After reset: word1 is zero, so the first draw is zero.
    r.beat = make_beat(ACT_DRAW32, 2'd0, '0, '0, '0); r.fixed = 1'b1;
    table_rows.push_back(r);
    r.fixed = 1'b0;
    r.beat = make_beat(ACT_DRAW31, 2'd0, '0, '0, '0); table_rows.push_back(r);
    r.beat = make_beat(ACT_FRAC53, 2'd0, '0, '0, '0); table_rows.push_back(r);
    // Empty bound returns min_value.
    r.fixed = 1'b1;
    r.beat = make_beat(ACT_BOUND, 2'd0, '0, 32'h7fff_ffff, 32'h8000_0000);
    r.want.bounded = 32'h7fff_ffff;
    table_rows.push_back(r);
    r.beat = make_beat(ACT_BOUND, 2'd0, '0, 32'd5, 32'd5);
    r.want.bounded = 32'd5;
    table_rows.push_back(r);
    r.beat = make_beat(ACT_NOP6, 2'd3, '1, '1, '1); r.want = zero_out;
    table_rows.push_back(r);
    r.beat = make_beat(ACT_NOP7, 2'd0, '0, '0, '0); table_rows.push_back(r);
    // All-zero state: load zeros, word 3 triggers the fix.
    r.fixed = 1'b1;
    for (int w = 0; w < 4; w++) begin
      r.beat = make_beat(ACT_LOAD, 2'(w), '0, '0, '0);
      table_rows.push_back(r);
    end
    r.fixed = 1'b0;
    r.beat = make_beat(ACT_FRAC53, 2'd0, '0, '0, '0); table_rows.push_back(r);
    // Zero state with no fix (only words 0 to 2 loaded), then a bounded draw.
    for (int w = 0; w < 3; w++) begin
      r.beat = make_beat(ACT_LOAD, 2'(w), '0, '0, '0);
      table_rows.push_back(r);
    end
    r.beat = make_beat(ACT_LOAD, 2'd1, '0, '0, '0); table_rows.push_back(r);
    r.beat = make_beat(ACT_LOAD, 2'd0, '0, '0, '0); table_rows.push_back(r);
    r.beat = make_beat(ACT_BOUND, 2'd0, '0, 32'h0000_0000, 32'h7fff_fffe);
    table_rows.push_back(r);
    r.beat = make_beat(ACT_SEED, 2'd0, '1, '0, '0); table_rows.push_back(r);
    r.beat = make_beat(ACT_SEED, 2'd0, '0, '0, '0); table_rows.push_back(r);
    r.beat = make_beat(ACT_LOAD, 2'd3, '1, '0, '0); table_rows.push_back(r);
    r.beat = make_beat(ACT_BOUND, 2'd0, '0, 32'h8000_0000, 32'h7fff_ffff);
    table_rows.push_back(r);
    r.beat = make_beat(ACT_BOUND, 2'd0, '0, 32'h8000_0000, 32'h0000_0000);
    table_rows.push_back(r);
    r.beat = make_beat(ACT_BOUND, 2'd0, '0, 32'hffff_fff0, 32'hffff_fff2);
    table_rows.push_back(r);
    r.beat = make_beat(ACT_DRAW32, 2'd0, '0, '0, '0); table_rows.push_back(r);
    r.beat = make_beat(ACT_FRAC53, 2'd0, '0, '0, '0); table_rows.push_back(r);

    // The predictor must run from the reset state, so restart it for the walk.
    gen_state[0] = 64'h9e3779b97f4a7c15;
    for (int i = 1; i < 4; i++) gen_state[i] = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (table_rows[i]) send_beat(table_rows[i].beat, table_rows[i].fixed,
                                      table_rows[i].want);
    for (int i = 0; i < RandomBeats; i++) begin
      if (i == RandomBeats / 3) hold_off = 1'b1;
      send_beat(random_beat(), 1'b0, zero_out);
    end
    push <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: stall pattern plus one long hold-off while the sender fills the block.
  initial begin
    int unsigned phase;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      phase++;
      pop <= (phase % 64) < 40 ? 1'b1 : ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk_i) begin
    outcome_t exp_out;
    if (rst_ni && pop && !empty) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_out = pending_outcomes.pop_front();
        beats_checked++;
        if (bounded_o != 0) bounded_seen++;
        if (draw_o !== exp_out.draw) begin
          $error("draw: expected %h, got %h", exp_out.draw, draw_o);
          errors++;
        end
        if (bounded_o !== exp_out.bounded) begin
          $error("bounded: expected %h, got %h", exp_out.bounded, bounded_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (!(stimulus_done && pending_outcomes.size() == 0) && cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CycleLimit) begin
      $display("xoshiro256ss_random_source_test: FAIL");
      $finish;
    end else begin
      repeat (200) @(posedge clk_i);
      $display("Covered %0d beats and %0d checked results, %0d nonzero bounded draws.",
               beats_sent, beats_checked, bounded_seen);
      if (errors == 0 && pending_outcomes.size() == 0)
        $display("xoshiro256ss_random_source_test: PASS");
      else
        $display("xoshiro256ss_random_source_test: FAIL");
      $finish;
    end
  end

endmodule
